// File: rtl/core/cds_pkg.sv
// Package for the card deck store: operation and status codes, widths and
// controller/datapath command and status structures. No dependencies.
package cds_pkg;

  localparam int Depth        = 64;
  localparam int InitialCards = 52;
  localparam int AddrW        = $clog2(Depth);
  localparam int CountW       = $clog2(Depth + 1);
  localparam int CardW        = 6;
  localparam int RndW         = 15;
  localparam int PosW         = 8;

  localparam logic [2:0] OP_PEEK        = 3'd0;
  localparam logic [2:0] OP_POP         = 3'd1;
  localparam logic [2:0] OP_INSERT      = 3'd2;
  localparam logic [2:0] OP_PUSH_TOP    = 3'd3;
  localparam logic [2:0] OP_PUSH_BOTTOM = 3'd4;
  localparam logic [2:0] OP_CUT         = 3'd5;
  localparam logic [2:0] OP_SWAP        = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Source of the RAM write data.
  typedef enum logic [1:0] {
    WR_RDATA = 2'd0,
    WR_HOLD  = 2'd1,
    WR_CARD  = 2'd2,
    WR_INIT  = 2'd3
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              rd_en;
    logic [AddrW-1:0]  rd_addr;
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr;
    wr_sel_e           wr_sel;
    logic              hold_en;    // capture read data into the hold register
    logic              card_load;  // capture the input card of a transaction
  } dp_cmd_t;

  typedef struct packed {
    logic [CardW-1:0] rd_data;
  } dp_sts_t;

endpackage

// File: rtl/core/cds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cds_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/core/cds_datapath.sv
// Datapath of the card deck store: the card RAM, a hold register and the
// captured input card. Depends on cds_pkg and cds_ram.
module cds_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cds_pkg::dp_cmd_t          cmd_i,
  input  logic [cds_pkg::CardW-1:0] card_i,
  output cds_pkg::dp_sts_t          sts_o
);

  localparam int CardW = cds_pkg::CardW;

  logic [CardW-1:0] rdata;
  logic [CardW-1:0] hold_q;
  logic [CardW-1:0] card_q;
  logic [CardW-1:0] wdata;

  // During the clearing pass an entry receives its own index below the
  // initial card count and zero from that count upward.
  always_comb begin
    case (cmd_i.wr_sel)
      cds_pkg::WR_HOLD: wdata = hold_q;
      cds_pkg::WR_CARD: wdata = card_q;
      cds_pkg::WR_INIT: begin
        wdata = (int'(cmd_i.wr_addr) < cds_pkg::InitialCards) ?
                CardW'(cmd_i.wr_addr) : '0;
      end
      default: wdata = rdata;
    endcase
  end

  cds_ram #(
    .Width(cds_pkg::CardW),
    .Depth(cds_pkg::Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cmd_i.wr_addr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      card_q <= '0;
    end else begin
      if (cmd_i.hold_en) begin
        hold_q <= rdata;
      end
      if (cmd_i.card_load) begin
        card_q <= card_i;
      end
    end
  end

  assign sts_o.rd_data = rdata;

endmodule

// File: rtl/core/cds_ctrl.sv
// Controller of the card deck store: sequences init, shifts, rotations,
// swaps and the restoring remainder; drives the datapath by commands.
// Depends on cds_pkg.
module cds_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 op_i,
  input  logic [cds_pkg::PosW-1:0]   position_i,
  input  logic [cds_pkg::RndW-1:0]   random_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [cds_pkg::CardW-1:0]  top_card_o,
  output logic [1:0]                 status_o,
  output logic [cds_pkg::CountW-1:0] card_count_o,
  output cds_pkg::dp_cmd_t           cmd_o,
  input  cds_pkg::dp_sts_t           sts_i
);

  localparam int AW = cds_pkg::AddrW;
  localparam int CW = cds_pkg::CountW;
  localparam int RW = cds_pkg::RndW;
  localparam int PW = cds_pkg::PosW;
  localparam int BW = $clog2(RW + 1);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_MOD, S_MOD_END, S_TOP_RD, S_TOP_WAIT, S_POP_RD,
    S_POP_WR, S_SHIFT_RD, S_SHIFT_WR, S_PUT, S_ROT_START, S_ROT_HOLD,
    S_ROT_RD, S_ROT_WR, S_ROT_LAST, S_SWAP_RD_A, S_SWAP_RD_B, S_SWAP_WR_A,
    S_SWAP_WR_B, S_DONE
  } state_e;

  state_e                    state_q;
  logic [2:0]                op_q;
  logic [RW-1:0]             rem_q;    // partial remainder
  logic [RW-1:0]             quo_q;    // dividend bits not yet shifted in
  logic [CW-1:0]             div_q;    // divisor
  logic [BW-1:0]             bit_q;    // remainder steps left
  logic [CW-1:0]             count_q;
  logic [CW-1:0]             idx_q;
  logic [CW-1:0]             pos_q;
  logic [CW-1:0]             swp_q;    // partner entry of a swap step
  logic [CW-1:0]             pass_q;   // single-step rotations left
  logic [cds_pkg::CardW-1:0] top_q;
  logic [1:0]                status_q;
  logic                      out_valid_q;
  logic                      accept;
  state_e                    acc_state;
  logic [1:0]                acc_status;
  logic [CW-1:0]             acc_pos;
  logic [RW:0]               trial;
  cds_pkg::dp_cmd_t          cmd;

  assign trial = {rem_q, quo_q[RW-1]} - {{(RW+1-CW){1'b0}}, div_q};

  assign in_stall_o   = (state_q != S_IDLE) || out_valid_q;
  assign accept       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign top_card_o   = top_q;
  assign status_o     = status_q;
  assign card_count_o = count_q;
  assign cmd_o        = cmd;

  // Decision taken when a transaction is accepted.
  always_comb begin
    acc_state  = S_DONE;
    acc_status = cds_pkg::ST_OK;
    acc_pos    = CW'(position_i);
    case (op_i)
      cds_pkg::OP_PEEK, cds_pkg::OP_POP: begin
        if (count_q == '0) acc_status = cds_pkg::ST_EMPTY;
        else acc_state = S_TOP_RD;
      end
      cds_pkg::OP_INSERT, cds_pkg::OP_PUSH_TOP, cds_pkg::OP_PUSH_BOTTOM: begin
        if (count_q == CW'(cds_pkg::Depth)) begin
          acc_status = cds_pkg::ST_FULL;
        end else if (op_i == cds_pkg::OP_PUSH_TOP || count_q == '0) begin
          acc_pos   = '0;
          acc_state = S_SHIFT_RD;
        end else if (op_i == cds_pkg::OP_PUSH_BOTTOM) begin
          acc_pos   = count_q;
          acc_state = S_SHIFT_RD;
        end else if (position_i > PW'(count_q)) begin
          acc_state = S_MOD;
        end else begin
          acc_state = S_SHIFT_RD;
        end
      end
      cds_pkg::OP_CUT: begin
        if (count_q == '0) acc_status = cds_pkg::ST_EMPTY;
        else acc_state = S_MOD;
      end
      cds_pkg::OP_SWAP: begin
        if (count_q == '0) acc_status = cds_pkg::ST_EMPTY;
        else if (position_i < PW'(count_q)) acc_state = S_MOD;
      end
      default: ;
    endcase
  end

  // Datapath commands decoded from state.
  always_comb begin
    cmd = '0;
    case (state_q)
      S_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = idx_q[AW-1:0];
        cmd.wr_sel  = cds_pkg::WR_INIT;
      end
      S_IDLE: cmd.card_load = accept;
      S_TOP_RD: cmd.rd_en = 1'b1;
      S_POP_RD, S_ROT_RD: begin
        cmd.rd_en   = (idx_q < count_q);
        cmd.rd_addr = idx_q[AW-1:0];
      end
      S_POP_WR, S_ROT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = AW'(idx_q - CW'(1));
      end
      S_SHIFT_RD: begin
        cmd.rd_en   = (idx_q > pos_q);
        cmd.rd_addr = AW'(idx_q - CW'(1));
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = idx_q[AW-1:0];
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = pos_q[AW-1:0];
        cmd.wr_sel  = cds_pkg::WR_CARD;
      end
      S_ROT_START: cmd.rd_en = (pass_q != '0);
      S_ROT_HOLD: cmd.hold_en = 1'b1;
      S_ROT_LAST: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = AW'(count_q - CW'(1));
        cmd.wr_sel  = cds_pkg::WR_HOLD;
      end
      S_SWAP_RD_A: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = pos_q[AW-1:0];
      end
      S_SWAP_RD_B: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = swp_q[AW-1:0];
        cmd.hold_en = 1'b1;
      end
      S_SWAP_WR_A: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = pos_q[AW-1:0];
      end
      S_SWAP_WR_B: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = swp_q[AW-1:0];
        cmd.wr_sel  = cds_pkg::WR_HOLD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      idx_q       <= '0;
      count_q     <= CW'(cds_pkg::InitialCards);
      out_valid_q <= 1'b0;
      op_q        <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      div_q       <= '0;
      bit_q       <= '0;
      pos_q       <= '0;
      swp_q       <= '0;
      pass_q      <= '0;
      top_q       <= '0;
      status_q    <= '0;
    end else begin
      if (state_q == S_DONE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          idx_q   <= idx_q + CW'(1);
          state_q <= (idx_q == CW'(cds_pkg::Depth - 1)) ? S_IDLE : S_INIT;
        end
        S_IDLE: begin
          if (accept) begin
            op_q     <= op_i;
            top_q    <= '0;
            status_q <= acc_status;
            pos_q    <= acc_pos;
            idx_q    <= count_q;
            bit_q    <= BW'(RW);
            rem_q    <= '0;
            quo_q    <= (op_i == cds_pkg::OP_SWAP) ? random_value_i : RW'(position_i);
            div_q    <= (op_i == cds_pkg::OP_SWAP) ? count_q - CW'(position_i) : count_q;
            state_q  <= acc_state;
          end
        end
        S_MOD: begin
          // One restoring-division step per cycle.
          rem_q   <= trial[RW] ? {rem_q[RW-2:0], quo_q[RW-1]} : trial[RW-1:0];
          quo_q   <= {quo_q[RW-2:0], 1'b0};
          bit_q   <= bit_q - BW'(1);
          state_q <= (bit_q == BW'(1)) ? S_MOD_END : S_MOD;
        end
        S_MOD_END: begin
          case (op_q)
            cds_pkg::OP_INSERT: begin
              pos_q   <= CW'(rem_q);
              state_q <= S_SHIFT_RD;
            end
            cds_pkg::OP_CUT: begin
              pass_q  <= CW'(rem_q);
              state_q <= S_ROT_START;
            end
            cds_pkg::OP_SWAP: begin
              swp_q   <= pos_q + CW'(rem_q);
              state_q <= S_SWAP_RD_A;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_TOP_RD: state_q <= S_TOP_WAIT;
        S_TOP_WAIT: begin
          top_q   <= sts_i.rd_data;
          idx_q   <= CW'(1);
          state_q <= (op_q == cds_pkg::OP_PEEK) ? S_DONE : S_POP_RD;
        end
        S_POP_RD: begin
          if (idx_q >= count_q) begin
            count_q <= count_q - CW'(1);
            state_q <= S_DONE;
          end else begin
            state_q <= S_POP_WR;
          end
        end
        S_POP_WR: begin
          idx_q   <= idx_q + CW'(1);
          state_q <= S_POP_RD;
        end
        S_SHIFT_RD: state_q <= (idx_q > pos_q) ? S_SHIFT_WR : S_PUT;
        S_SHIFT_WR: begin
          idx_q   <= idx_q - CW'(1);
          state_q <= S_SHIFT_RD;
        end
        S_PUT: begin
          count_q <= count_q + CW'(1);
          state_q <= S_DONE;
        end
        S_ROT_START: state_q <= (pass_q == '0) ? S_DONE : S_ROT_HOLD;
        S_ROT_HOLD: begin
          idx_q   <= CW'(1);
          state_q <= S_ROT_RD;
        end
        S_ROT_RD: state_q <= (idx_q >= count_q) ? S_ROT_LAST : S_ROT_WR;
        S_ROT_WR: begin
          idx_q   <= idx_q + CW'(1);
          state_q <= S_ROT_RD;
        end
        S_ROT_LAST: begin
          pass_q  <= pass_q - CW'(1);
          state_q <= S_ROT_START;
        end
        S_SWAP_RD_A: state_q <= S_SWAP_RD_B;
        S_SWAP_RD_B: state_q <= S_SWAP_WR_A;
        S_SWAP_WR_A: state_q <= S_SWAP_WR_B;
        S_SWAP_WR_B: state_q <= S_DONE;
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/card_deck_store.sv
// Top level of the card deck store: controller plus datapath.
// Depends on cds_pkg, cds_ctrl, cds_datapath and cds_ram.
//
// The card deck store holds up to 64 six-bit card codes in a RAM, entry 0
// being the top. After reset a clearing pass writes codes 0 to 51 and zero
// above them; no transaction is accepted meanwhile. One operation is handled
// at a time and gives one result transaction; the input stalls from the
// accepting edge until that result has been taken. An operation on an empty
// or full store, an unused code or a swap index at or past the count goes
// straight to its result. Insert beyond the count and cut first take a
// bit-serial remainder by the count; an in-range swap takes one by the count
// less the position, then swaps two entries. A cut rotates one card at a
// time, because the RAM moves one card per read and write pair.
module card_deck_store (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] op_i,
  input  logic [5:0] card_code_i,
  input  logic [7:0] position_i,
  input  logic [14:0] random_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] top_card_o,
  output logic [1:0] status_o,
  output logic [6:0] card_count_o
);

  cds_pkg::dp_cmd_t cmd;
  cds_pkg::dp_sts_t sts;

  // The controller sequences every operation and owns the count; the card
  // of a transaction is captured in the datapath when it is accepted.
  cds_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .position_i    (position_i),
    .random_value_i(random_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .top_card_o    (top_card_o),
    .status_o      (status_o),
    .card_count_o  (card_count_o),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  cds_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .card_i(card_code_i),
    .sts_o (sts)
  );

  // The count never exceeds the store depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    card_count_o <= 7'd64) else $error("card count beyond depth");

  // No input is accepted while a result waits.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept while result pending");

  // A full status only reports the full count.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == cds_pkg::ST_FULL) |-> card_count_o == 7'd64)
    else $error("full status with room left");

endmodule
